FILE: rtl/ske_pkg.sv
// ----------------------------------------------------------------------------
// ske_pkg
// Shared widths, codes and reset values for the SPH kernel evaluator.
// ----------------------------------------------------------------------------
package ske_pkg;

	// Field and datapath widths.
	localparam int DATA_W   = 32;
	localparam int COEF_W   = 48;
	localparam int OP_W     = 2;
	localparam int OPND_W   = 64;
	localparam int P_W      = 62;
	localparam int R2_W     = 64;
	localparam int ROOT_W   = 32;
	localparam int SQ_REM_W = 35;
	localparam int CFG_W    = 64;
	localparam int ADDR_W   = 6;

	// Default fixed-point formats.
	localparam int FRAC_BITS_DEF      = 16;
	localparam int COEF_FRAC_BITS_DEF = 24;

	// Kernel selection codes.
	typedef enum logic [OP_W-1:0] {
		OP_POLY6 = 2'd0,
		OP_VISC  = 2'd1,
		OP_SPIKY = 2'd2,
		OP_GRAD  = 2'd3
	} op_t;

	// Register indexes; the register at index i lies at byte address 8*i.
	typedef enum logic [2:0] {
		REG_H        = 3'd0,
		REG_H2       = 3'd1,
		REG_INV_H2   = 3'd2,
		REG_INV_2H3  = 3'd3,
		REG_POLY6    = 3'd4,
		REG_SPIKY    = 3'd5,
		REG_GRAD     = 3'd6
	} reg_idx_t;

	// Register reset values.
	localparam logic [DATA_W-1:0] RST_H       = 32'd65536;
	localparam logic [DATA_W-1:0] RST_H2      = 32'd65536;
	localparam logic [DATA_W-1:0] RST_INV_H2  = 32'd65536;
	localparam logic [DATA_W-1:0] RST_INV_2H3 = 32'd32768;
	localparam logic [COEF_W-1:0] RST_POLY6   = 48'd26284544;
	localparam logic [COEF_W-1:0] RST_SPIKY   = 48'd80105300;
	localparam logic [COEF_W-1:0] RST_GRAD    = 48'hFFFFF69993B4;

endpackage

FILE: rtl/sph_kernel_evaluator.sv
// ----------------------------------------------------------------------------
// sph_kernel_evaluator
// SPH smoothing kernels: poly6, viscosity shape, spiky and poly6 gradient.
// ----------------------------------------------------------------------------
// Usage: a request (opcode and offset vector) is taken on each rising edge
// with start high; busy stays low, so a new request may follow every cycle.
// Each request yields one result, shown for one cycle with result_valid
// high; results leave in request order from the output registers that
// follow the combine stage.
// The receiver cannot stall; results must be taken as they come.
// The latency is set by two rows of cells: a square root chain of 32 cells,
// one root bit each, followed by a restoring divider chain of 33 + FRAC_BITS
// cells for the h/(2r) term. All other kernels run beside them in two-stage
// multipliers and wait in shift lines. Throughput is one request per cycle.
// Kernel constants live in seven APB registers of 32 or 48 bits at byte address 8*i;
// they must only be written while no request is in flight.
// Reset clears the pipeline valid bits and loads the radius-1 defaults.
// ----------------------------------------------------------------------------
module sph_kernel_evaluator #(
	parameter int FRAC_BITS      = ske_pkg::FRAC_BITS_DEF,
	parameter int COEF_FRAC_BITS = ske_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ske_pkg::OP_W-1:0]           opcode,
	input  logic signed [ske_pkg::DATA_W-1:0]  offset_x,
	input  logic signed [ske_pkg::DATA_W-1:0]  offset_y,
	input  logic signed [ske_pkg::DATA_W-1:0]  offset_z,
	output logic                              result_valid,
	output logic signed [ske_pkg::DATA_W-1:0]  result_x,
	output logic signed [ske_pkg::DATA_W-1:0]  result_y,
	output logic signed [ske_pkg::DATA_W-1:0]  result_z,
	output logic                              beyond_radius,
	output logic                              saturated,
	output logic                              zero_distance,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ske_pkg::ADDR_W-1:0]         paddr,
	input  logic [ske_pkg::CFG_W-1:0]          pwdata,
	output logic [ske_pkg::CFG_W-1:0]          prdata,
	output logic                              pready
);
	import ske_pkg::*;

	// Pipeline schedule.
	localparam int MUL_LAT  = 2;
	localparam int NUM_W    = DATA_W + FRAC_BITS + 1;
	localparam int DEN_W    = ROOT_W + 1;
	localparam int S_R2     = 3;
	localparam int S_R      = S_R2 + ROOT_W;
	localparam int S_DIV_IN = S_R + 1;
	localparam int S_C      = S_DIV_IN + NUM_W;
	localparam int S_P6     = S_R2 + 1 + 3 * MUL_LAT;
	localparam int S_Q2     = S_R2 + MUL_LAT;
	localparam int S_W2     = S_Q2 + 1 + MUL_LAT;
	localparam int S_GR     = S_W2 + 2 * MUL_LAT;
	localparam int S_A      = S_R + 2 * MUL_LAT;
	localparam int S_SP     = S_DIV_IN + 3 * MUL_LAT;
	localparam logic [63:0] ONE  = 64'(1) << FRAC_BITS;
	localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

	// Configuration registers.
	logic [DATA_W-1:0] reg_h_q, reg_h2_q, reg_ih2_q, reg_i2h3_q;
	logic [COEF_W-1:0] reg_p6_q, reg_sp_q, reg_gr_q;
	logic              cfg_wr;

	// Front end.
	logic                     valid_s1;
	logic [OP_W-1:0]          op_s1;
	logic signed [DATA_W-1:0] d_s1 [3];
	logic [63:0]              sq_s2 [3];
	logic [R2_W-1:0]          r2_s3;
	logic                     beyond_s3;

	// Square root chain.
	logic [R2_W-1:0]     sq_rad [ROOT_W+1];
	logic [SQ_REM_W-1:0] sq_rem [ROOT_W+1];
	logic [ROOT_W-1:0]   sq_root [ROOT_W+1];
	logic [ROOT_W-1:0]   r_s35;

	// Poly6 path.
	logic [63:0]    dq_s4, dq_d;
	logic [P_W-1:0] p6_a, p6_b, p6_m;
	logic           p6_sat_a, p6_sat_b, p6_sat_m;

	// Gradient and shared r^2/h^2 path.
	logic [P_W-1:0]    q2_m;
	logic              q2_sat;
	logic [63:0]       wv, wm_s6;
	logic              w_sat_s6;
	logic [P_W-1:0]    w2_m;
	logic              w2_sat;
	logic [COEF_W-1:0] cm;

	// Viscosity path.
	logic [R2_W-1:0]  r2_at_r;
	logic [P_W-1:0]   va_a, va_m;
	logic             va_sat_a, va_sat_m;
	logic [NUM_W-1:0] dv_nq [NUM_W+1];
	logic [DEN_W:0]   dv_rem [NUM_W+1];
	logic [DEN_W-1:0] dv_den [NUM_W+1];

	// Spiky path.
	logic signed [DATA_W:0] t_s36;
	logic [63:0]            tm, tm_d;
	logic [P_W-1:0]         sp_a, sp_b, sp_m;
	logic                   sp_sat_a, sp_sat_b, sp_sat_m;

	// Aligned values at the combine stage.
	logic [P_W-1:0]  p6_c, b_c, a_c, sp_c, g_c [3];
	logic            p6_sat_c, b_sat_c, a_sat_c, sp_sat_c, g_sat_c [3];
	logic            gneg_c [3];
	logic            tneg_c, rz_c, beyond_c, valid_c;
	logic [OP_W-1:0] op_c;

	// Combine stage.
	logic signed [63:0] v;
	logic [63:0]        vm;
	logic [DATA_W:0]    cl_p6, cl_sp, cl_v, cl_g [3];
	logic [DATA_W-1:0]  rx_w, ry_w, rz_w;
	logic               sat_w, zd_w, bey_w;

	// Output registers.
	logic              valid_q, beyond_q, sat_q, zd_q;
	logic [DATA_W-1:0] rx_q, ry_q, rz_q;
	logic [OP_W-1:0]   op_q;

	function automatic logic [DATA_W:0] clamp32(input logic neg, input logic [63:0] m);
		logic [63:0] n;
		n = 64'd0 - m;
		if (!neg && m > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
		if (neg && m > 64'h8000_0000) return {1'b1, 32'h8000_0000};
		return neg ? {1'b0, n[DATA_W-1:0]} : {1'b0, m[DATA_W-1:0]};
	endfunction

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] d);
		return d[DATA_W-1] ? DATA_W'(-d) : DATA_W'(d);
	endfunction

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_h_q    <= RST_H;
			reg_h2_q   <= RST_H2;
			reg_ih2_q  <= RST_INV_H2;
			reg_i2h3_q <= RST_INV_2H3;
			reg_p6_q   <= RST_POLY6;
			reg_sp_q   <= RST_SPIKY;
			reg_gr_q   <= RST_GRAD;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[ADDR_W-1:3]))
				REG_H:       reg_h_q    <= pwdata[DATA_W-1:0];
				REG_H2:      reg_h2_q   <= pwdata[DATA_W-1:0];
				REG_INV_H2:  reg_ih2_q  <= pwdata[DATA_W-1:0];
				REG_INV_2H3: reg_i2h3_q <= pwdata[DATA_W-1:0];
				REG_POLY6:   reg_p6_q   <= pwdata[COEF_W-1:0];
				REG_SPIKY:   reg_sp_q   <= pwdata[COEF_W-1:0];
				REG_GRAD:    reg_gr_q   <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_idx_t'(paddr[ADDR_W-1:3]))
			REG_H:       prdata = CFG_W'(reg_h_q);
			REG_H2:      prdata = CFG_W'(reg_h2_q);
			REG_INV_H2:  prdata = CFG_W'(reg_ih2_q);
			REG_INV_2H3: prdata = CFG_W'(reg_i2h3_q);
			REG_POLY6:   prdata = CFG_W'(reg_p6_q);
			REG_SPIKY:   prdata = CFG_W'(reg_sp_q);
			REG_GRAD:    prdata = CFG_W'(reg_gr_q);
			default:     prdata = '0;
		endcase
	end

	// Request capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= start;
	end

	always_ff @(posedge clk) begin
		op_s1   <= opcode;
		d_s1[0] <= offset_x;
		d_s1[1] <= offset_y;
		d_s1[2] <= offset_z;
	end

	// Squares, then r^2 and the cutoff test.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) sq_s2[i] <= mag32(d_s1[i]) * mag32(d_s1[i]);
		r2_s3     <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		beyond_s3 <= (sq_s2[0] + sq_s2[1] + sq_s2[2]) > (64'(reg_h2_q) << FRAC_BITS);
	end

	// Square root row.
	assign sq_rad[0]  = r2_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		ske_sqrt_cell u_cell (
			.clk    (clk),
			.rad_i  (sq_rad[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.rad_o  (sq_rad[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1])
		);
	end

	assign r_s35 = sq_root[ROOT_W];

	// Poly6: coef * (h^2 - r^2)^3.
	always_ff @(posedge clk) begin
		dq_s4 <= ((64'(reg_h2_q) << FRAC_BITS) - r2_s3 + HALF) >> FRAC_BITS;
	end

	ske_mul #(.SHIFT(FRAC_BITS)) u_p6_a (
		.clk(clk), .arst_n(arst_n), .a(dq_s4), .b(dq_s4), .sat_in(1'b0),
		.p(p6_a), .sat_out(p6_sat_a)
	);
	ske_delay #(.W(64), .DEPTH(MUL_LAT)) u_dq_d (
		.clk(clk), .arst_n(arst_n), .din(dq_s4), .dout(dq_d)
	);
	ske_mul #(.SHIFT(FRAC_BITS)) u_p6_b (
		.clk(clk), .arst_n(arst_n), .a({2'b00, p6_a}), .b(dq_d), .sat_in(p6_sat_a),
		.p(p6_b), .sat_out(p6_sat_b)
	);
	ske_mul #(.SHIFT(COEF_FRAC_BITS)) u_p6_m (
		.clk(clk), .arst_n(arst_n), .a({2'b00, p6_b}), .b(64'(reg_p6_q)),
		.sat_in(p6_sat_b), .p(p6_m), .sat_out(p6_sat_m)
	);

	// r^2/h^2, shared by the gradient and viscosity kernels.
	ske_mul #(.SHIFT(2 * FRAC_BITS)) u_q2 (
		.clk(clk), .arst_n(arst_n), .a(r2_s3), .b(64'(reg_ih2_q)), .sat_in(1'b0),
		.p(q2_m), .sat_out(q2_sat)
	);

	// Gradient weight (1 - r^2/h^2)^2.
	assign wv = ONE - {2'b00, q2_m};

	always_ff @(posedge clk) begin
		wm_s6    <= wv[63] ? 64'd0 - wv : wv;
		w_sat_s6 <= q2_sat;
	end

	ske_mul #(.SHIFT(FRAC_BITS)) u_w2 (
		.clk(clk), .arst_n(arst_n), .a(wm_s6), .b(wm_s6), .sat_in(w_sat_s6),
		.p(w2_m), .sat_out(w2_sat)
	);

	assign cm = reg_gr_q[COEF_W-1] ? COEF_W'(0) - reg_gr_q : reg_gr_q;

	// Gradient lanes: coef * d * weight.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [DATA_W-1:0] d_d;
		logic [P_W-1:0]           g_a, g_m;
		logic                     g_sat_a, g_sat_m, dneg_c;

		ske_delay #(.W(DATA_W), .DEPTH(S_W2 - 1)) u_d (
			.clk(clk), .arst_n(arst_n), .din(d_s1[i]), .dout(d_d)
		);
		ske_mul #(.SHIFT(FRAC_BITS)) u_g_a (
			.clk(clk), .arst_n(arst_n), .a(64'(mag32(d_d))), .b({2'b00, w2_m}),
			.sat_in(w2_sat), .p(g_a), .sat_out(g_sat_a)
		);
		ske_mul #(.SHIFT(COEF_FRAC_BITS)) u_g_m (
			.clk(clk), .arst_n(arst_n), .a({2'b00, g_a}), .b(64'(cm)),
			.sat_in(g_sat_a), .p(g_m), .sat_out(g_sat_m)
		);
		ske_delay #(.W(P_W + 1), .DEPTH(S_C - S_GR)) u_g_c (
			.clk(clk), .arst_n(arst_n), .din({g_sat_m, g_m}), .dout({g_sat_c[i], g_c[i]})
		);
		ske_delay #(.W(1), .DEPTH(S_C - 1)) u_s_c (
			.clk(clk), .arst_n(arst_n), .din(d_s1[i][DATA_W-1]), .dout(dneg_c)
		);

		assign gneg_c[i] = (dneg_c != reg_gr_q[COEF_W-1]) && (g_c[i] != '0);
	end

	// Viscosity: r^3/(2h^3) term.
	ske_delay #(.W(R2_W), .DEPTH(ROOT_W)) u_r2_d (
		.clk(clk), .arst_n(arst_n), .din(r2_s3), .dout(r2_at_r)
	);
	ske_mul #(.SHIFT(2 * FRAC_BITS)) u_va_a (
		.clk(clk), .arst_n(arst_n), .a(r2_at_r), .b(64'(r_s35)), .sat_in(1'b0),
		.p(va_a), .sat_out(va_sat_a)
	);
	ske_mul #(.SHIFT(FRAC_BITS)) u_va_m (
		.clk(clk), .arst_n(arst_n), .a({2'b00, va_a}), .b(64'(reg_i2h3_q)),
		.sat_in(va_sat_a), .p(va_m), .sat_out(va_sat_m)
	);

	// Viscosity: rounded h/(2r) through the divider row.
	always_ff @(posedge clk) begin
		dv_nq[0]  <= (NUM_W'(reg_h_q) << FRAC_BITS) + NUM_W'(r_s35);
		dv_den[0] <= {r_s35, 1'b0};
		t_s36     <= $signed({1'b0, reg_h_q}) - $signed({1'b0, r_s35});
	end

	assign dv_rem[0] = '0;

	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		ske_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_cell (
			.clk   (clk),
			.nq_i  (dv_nq[k]),
			.rem_i (dv_rem[k]),
			.den_i (dv_den[k]),
			.nq_o  (dv_nq[k+1]),
			.rem_o (dv_rem[k+1]),
			.den_o (dv_den[k+1])
		);
	end

	// Spiky: coef * (h - r)^3 with the sign of h - r.
	assign tm = 64'(t_s36[DATA_W] ? -t_s36 : t_s36);

	ske_mul #(.SHIFT(FRAC_BITS)) u_sp_a (
		.clk(clk), .arst_n(arst_n), .a(tm), .b(tm), .sat_in(1'b0),
		.p(sp_a), .sat_out(sp_sat_a)
	);
	ske_delay #(.W(64), .DEPTH(MUL_LAT)) u_tm_d (
		.clk(clk), .arst_n(arst_n), .din(tm), .dout(tm_d)
	);
	ske_mul #(.SHIFT(FRAC_BITS)) u_sp_b (
		.clk(clk), .arst_n(arst_n), .a({2'b00, sp_a}), .b(tm_d), .sat_in(sp_sat_a),
		.p(sp_b), .sat_out(sp_sat_b)
	);
	ske_mul #(.SHIFT(COEF_FRAC_BITS)) u_sp_m (
		.clk(clk), .arst_n(arst_n), .a({2'b00, sp_b}), .b(64'(reg_sp_q)),
		.sat_in(sp_sat_b), .p(sp_m), .sat_out(sp_sat_m)
	);

	// Align every path with the divider output.
	ske_delay #(.W(P_W + 1), .DEPTH(S_C - S_P6)) u_p6_c (
		.clk(clk), .arst_n(arst_n), .din({p6_sat_m, p6_m}), .dout({p6_sat_c, p6_c})
	);
	ske_delay #(.W(P_W + 1), .DEPTH(S_C - S_Q2)) u_b_c (
		.clk(clk), .arst_n(arst_n), .din({q2_sat, q2_m}), .dout({b_sat_c, b_c})
	);
	ske_delay #(.W(P_W + 1), .DEPTH(S_C - S_A)) u_a_c (
		.clk(clk), .arst_n(arst_n), .din({va_sat_m, va_m}), .dout({a_sat_c, a_c})
	);
	ske_delay #(.W(P_W + 1), .DEPTH(S_C - S_SP)) u_sp_c (
		.clk(clk), .arst_n(arst_n), .din({sp_sat_m, sp_m}), .dout({sp_sat_c, sp_c})
	);
	ske_delay #(.W(1), .DEPTH(S_C - S_DIV_IN)) u_tneg_c (
		.clk(clk), .arst_n(arst_n), .din(t_s36[DATA_W]), .dout(tneg_c)
	);
	ske_delay #(.W(1), .DEPTH(S_C - S_R)) u_rz_c (
		.clk(clk), .arst_n(arst_n), .din(r_s35 == '0), .dout(rz_c)
	);
	ske_delay #(.W(1), .DEPTH(S_C - S_R2)) u_bey_c (
		.clk(clk), .arst_n(arst_n), .din(beyond_s3), .dout(beyond_c)
	);
	ske_delay #(.W(OP_W + 1), .DEPTH(S_C - 1)) u_op_c (
		.clk(clk), .arst_n(arst_n), .din({valid_s1, op_s1}), .dout({valid_c, op_c})
	);

	// Combine, clamp and select.
	always_comb begin
		v  = $signed({2'b00, b_c}) + $signed(64'(dv_nq[NUM_W]))
		   - $signed({2'b00, a_c}) - $signed(ONE);
		vm = v[63] ? 64'd0 - v : v;
		cl_p6 = clamp32(1'b0, {2'b00, p6_c});
		cl_sp = clamp32(tneg_c && (sp_c != '0), {2'b00, sp_c});
		cl_v  = clamp32(v[63], vm);
		for (int i = 0; i < 3; i++) cl_g[i] = clamp32(gneg_c[i], {2'b00, g_c[i]});
		zd_w  = 1'b0;
		bey_w = 1'b0;
		case (op_t'(op_c))
			OP_POLY6: begin
				rx_w  = cl_p6[DATA_W-1:0];
				ry_w  = rx_w;
				rz_w  = rx_w;
				sat_w = p6_sat_c | cl_p6[DATA_W];
			end
			OP_VISC: begin
				rx_w  = cl_v[DATA_W-1:0];
				ry_w  = rx_w;
				rz_w  = rx_w;
				sat_w = a_sat_c | b_sat_c | cl_v[DATA_W];
			end
			OP_SPIKY: begin
				rx_w  = cl_sp[DATA_W-1:0];
				ry_w  = rx_w;
				rz_w  = rx_w;
				sat_w = sp_sat_c | cl_sp[DATA_W];
			end
			default: begin
				rx_w  = cl_g[0][DATA_W-1:0];
				ry_w  = cl_g[1][DATA_W-1:0];
				rz_w  = cl_g[2][DATA_W-1:0];
				sat_w = g_sat_c[0] | g_sat_c[1] | g_sat_c[2]
				      | cl_g[0][DATA_W] | cl_g[1][DATA_W] | cl_g[2][DATA_W];
			end
		endcase
		// Outside the radius everything reads zero.
		if (beyond_c) begin
			rx_w  = '0;
			ry_w  = '0;
			rz_w  = '0;
			sat_w = 1'b0;
			bey_w = 1'b1;
		end else if (op_t'(op_c) == OP_VISC && rz_c) begin
			rx_w  = 32'h7FFF_FFFF;
			ry_w  = 32'h7FFF_FFFF;
			rz_w  = 32'h7FFF_FFFF;
			sat_w = 1'b1;
			zd_w  = 1'b1;
		end
	end

	// Output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else         valid_q <= valid_c;
	end

	always_ff @(posedge clk) begin
		rx_q     <= rx_w;
		ry_q     <= ry_w;
		rz_q     <= rz_w;
		beyond_q <= bey_w;
		sat_q    <= sat_w;
		zd_q     <= zd_w;
		op_q     <= op_c;
	end

	assign result_valid  = valid_q;
	assign result_x      = rx_q;
	assign result_y      = ry_q;
	assign result_z      = rz_q;
	assign beyond_radius = beyond_q;
	assign saturated     = sat_q;
	assign zero_distance = zd_q;

	// Every request comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(S_C + 1) result_valid)
		else $error("result did not follow request at fixed latency");

	// A zero distance result is always reported as clamped.
	a_zd_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_distance |-> saturated && !beyond_radius)
		else $error("zero distance without saturation");

	// Outside the radius x and z are zero; saturated and zero_distance stay low.
	a_beyond: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && beyond_radius |->
			result_x == '0 && result_z == '0 && !saturated && !zero_distance)
		else $error("nonzero result beyond radius");

	// Scalar kernels fill all three lanes alike.
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && op_t'(op_q) != OP_GRAD |->
			result_x == result_y && result_y == result_z)
		else $error("scalar kernel lanes differ");

endmodule

FILE: rtl/ske_delay.sv
// ----------------------------------------------------------------------------
// ske_delay
// Fixed-length shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module ske_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_q [DEPTH];

	// Shift one place per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

FILE: rtl/ske_mul.sv
// ----------------------------------------------------------------------------
// ske_mul
// Two-stage 64x64 multiply, shift right with rounding, cap at 2^62-1.
// ----------------------------------------------------------------------------
module ske_mul #(
	parameter int SHIFT = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ske_pkg::OPND_W-1:0] a,
	input  logic [ske_pkg::OPND_W-1:0] b,
	input  logic                      sat_in,
	output logic [ske_pkg::P_W-1:0]    p,
	output logic                      sat_out
);
	import ske_pkg::*;

	localparam logic [128:0] HALF = 129'(1) << (SHIFT - 1);

	logic [63:0]    pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic           sat_s1;
	logic [128:0]   sum_w, shifted_w;
	logic           over_w;
	logic [P_W-1:0] p_s2;
	logic           sat_s2;

	// Four 32x32 partial products.
	always_ff @(posedge clk) begin
		pp_ll_s1 <= a[31:0]  * b[31:0];
		pp_lh_s1 <= a[31:0]  * b[63:32];
		pp_hl_s1 <= a[63:32] * b[31:0];
		pp_hh_s1 <= a[63:32] * b[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_s1 <= 1'b0;
			sat_s2 <= 1'b0;
		end else begin
			sat_s1 <= sat_in;
			sat_s2 <= sat_s1 | over_w;
		end
	end

	// Sum, round half up, shift and cap.
	always_comb begin
		sum_w = 129'({pp_hh_s1, 64'd0}) + 129'({pp_lh_s1, 32'd0})
		      + 129'({pp_hl_s1, 32'd0}) + 129'(pp_ll_s1) + HALF;
		shifted_w = sum_w >> SHIFT;
		over_w = |shifted_w[128:P_W];
	end

	always_ff @(posedge clk) begin
		p_s2 <= over_w ? {P_W{1'b1}} : shifted_w[P_W-1:0];
	end

	assign p       = p_s2;
	assign sat_out = sat_s2;

endmodule

FILE: rtl/ske_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ske_sqrt_cell
// One digit of a floor integer square root; one cell per result bit.
// ----------------------------------------------------------------------------
module ske_sqrt_cell (
	input  logic                        clk,
	input  logic [ske_pkg::R2_W-1:0]     rad_i,
	input  logic [ske_pkg::SQ_REM_W-1:0] rem_i,
	input  logic [ske_pkg::ROOT_W-1:0]   root_i,
	output logic [ske_pkg::R2_W-1:0]     rad_o,
	output logic [ske_pkg::SQ_REM_W-1:0] rem_o,
	output logic [ske_pkg::ROOT_W-1:0]   root_o
);
	import ske_pkg::*;

	logic [SQ_REM_W-1:0] cand, trial;
	logic                ge;
	logic [R2_W-1:0]     rad_q;
	logic [SQ_REM_W-1:0] rem_q;
	logic [ROOT_W-1:0]   root_q;

	// Bring in the next two radicand bits and try the next root bit.
	always_comb begin
		cand  = {rem_i[SQ_REM_W-3:0], rad_i[R2_W-1 -: 2]};
		trial = SQ_REM_W'({root_i, 2'b01});
		ge    = cand >= trial;
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_i[R2_W-3:0], 2'b00};
		rem_q  <= ge ? cand - trial : cand;
		root_q <= {root_i[ROOT_W-2:0], ge};
	end

	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule

FILE: rtl/ske_div_cell.sv
// ----------------------------------------------------------------------------
// ske_div_cell
// One step of a restoring divider; one cell per quotient bit.
// ----------------------------------------------------------------------------
module ske_div_cell #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] nq_i,
	input  logic [DEN_W:0]   rem_i,
	input  logic [DEN_W-1:0] den_i,
	output logic [NUM_W-1:0] nq_o,
	output logic [DEN_W:0]   rem_o,
	output logic [DEN_W-1:0] den_o
);

	logic [DEN_W:0]   cand;
	logic             ge;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;

	// Shift in the next numerator bit and subtract when it fits.
	always_comb begin
		cand = {rem_i[DEN_W-1:0], nq_i[NUM_W-1]};
		ge   = cand >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		nq_q  <= {nq_i[NUM_W-2:0], ge};
		rem_q <= ge ? cand - {1'b0, den_i} : cand;
		den_q <= den_i;
	end

	assign nq_o  = nq_q;
	assign rem_o = rem_q;
	assign den_o = den_q;

endmodule

FILE: sim/sph_kernel_evaluator_tb.sv
// ----------------------------------------------------------------------------
// sph_kernel_evaluator_tb
// Drives kernel requests and APB register writes into the SPH kernel
// evaluator, predicts every result in fixed point and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_kernel_evaluator_tb;
	import ske_pkg::*;

	localparam logic [63:0] SAT_CAP   = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MASK48    = 64'hFFFF_FFFF_FFFF;
	localparam int          QF        = 16;
	localparam int          QC        = 24;
	localparam int          DRAIN_CYC = 120;
	localparam int          MAX_CYC   = 600000;

	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rz;
		logic        beyond;
		logic        sat;
		logic        zdist;
	} kernel_out_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OP_W-1:0] opcode;
	logic signed [DATA_W-1:0] offset_x, offset_y, offset_z;
	logic result_valid;
	logic signed [DATA_W-1:0] result_x, result_y, result_z;
	logic beyond_radius, saturated, zero_distance;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0] pwdata;
	logic [CFG_W-1:0] prdata;
	logic pready;

	// Shadow copy of the kernel registers.
	logic [63:0] kreg [7];
	kernel_out_t pending_results [$];
	int errors;
	int cycles;
	bit clip;
	// Set while start is being held high by the sender.
	bit driving;

	sph_kernel_evaluator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .offset_x(offset_x), .offset_y(offset_y),
		.offset_z(offset_z), .result_valid(result_valid),
		.result_x(result_x), .result_y(result_y), .result_z(result_z),
		.beyond_radius(beyond_radius), .saturated(saturated),
		.zero_distance(zero_distance), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Rounded, capped fixed-point product.
	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [127:0] p;
		p = a * b;
		p = (p + (128'd1 << (s - 1))) >> s;
		if (p > SAT_CAP) begin
			clip = 1'b1;
			return SAT_CAP;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] mag64(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] clamp_q(input bit neg, input logic [63:0] m);
		if (!neg && m > 64'h7FFF_FFFF) begin
			clip = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (neg && m > 64'h8000_0000) begin
			clip = 1'b1;
			return 32'h8000_0000;
		end
		return neg ? 32'(-m) : m[31:0];
	endfunction

	// Expected kernel output for one request under the current registers.
	function automatic kernel_out_t kernel_eval(input op_t op, input logic signed [31:0] dx,
			input logic signed [31:0] dy, input logic signed [31:0] dz);
		kernel_out_t o;
		longint d [3];
		logic [63:0] r2, r, one, q2, wm, w2, cm, t, dq, p, m, tm, a, b, c;
		longint w, cs, ts, v;
		bit neg;
		o = '0;
		clip = 1'b0;
		one = 64'd1 << QF;
		d[0] = longint'(dx);
		d[1] = longint'(dy);
		d[2] = longint'(dz);
		r2 = 0;
		for (int i = 0; i < 3; i++) r2 = r2 + mag64(d[i]) * mag64(d[i]);
		r = floor_sqrt(r2);
		if (r2 > (kreg[REG_H2] << QF)) begin
			o.beyond = 1'b1;
			return o;
		end
		if (op == OP_GRAD) begin
			q2 = fx_mul(r2, kreg[REG_INV_H2], 2 * QF);
			w = longint'(one) - longint'(q2);
			wm = mag64(w);
			w2 = fx_mul(wm, wm, QF);
			cs = longint'({{16{kreg[REG_GRAD][47]}}, kreg[REG_GRAD][47:0]});
			cm = mag64(cs);
			t = fx_mul(fx_mul(mag64(d[0]), w2, QF), cm, QC);
			o.rx = clamp_q(((d[0] < 0) != (cs < 0)) && t != 0, t);
			t = fx_mul(fx_mul(mag64(d[1]), w2, QF), cm, QC);
			o.ry = clamp_q(((d[1] < 0) != (cs < 0)) && t != 0, t);
			t = fx_mul(fx_mul(mag64(d[2]), w2, QF), cm, QC);
			o.rz = clamp_q(((d[2] < 0) != (cs < 0)) && t != 0, t);
		end else begin
			neg = 1'b0;
			if (op == OP_POLY6) begin
				dq = ((kreg[REG_H2] << QF) - r2 + (one >> 1)) >> QF;
				p = fx_mul(fx_mul(dq, dq, QF), dq, QF);
				m = fx_mul(p, kreg[REG_POLY6], QC);
			end else if (op == OP_SPIKY) begin
				ts = longint'(kreg[REG_H]) - longint'(r);
				tm = mag64(ts);
				p = fx_mul(fx_mul(tm, tm, QF), tm, QF);
				m = fx_mul(p, kreg[REG_SPIKY], QC);
				neg = ts < 0 && m != 0;
			end else begin
				// Viscosity at zero distance: the h/(2r) term is infinite.
				if (r == 0) begin
					o.rx = 32'h7FFF_FFFF;
					o.ry = 32'h7FFF_FFFF;
					o.rz = 32'h7FFF_FFFF;
					o.sat = 1'b1;
					o.zdist = 1'b1;
					return o;
				end
				a = fx_mul(fx_mul(r2, r, 2 * QF), kreg[REG_INV_2H3], QF);
				b = fx_mul(r2, kreg[REG_INV_H2], 2 * QF);
				c = ((kreg[REG_H] << QF) + r) / (2 * r);
				v = longint'(b) + longint'(c) - longint'(a) - longint'(one);
				neg = v < 0;
				m = mag64(v);
			end
			o.rx = clamp_q(neg, m);
			o.ry = o.rx;
			o.rz = o.rx;
		end
		o.sat = clip;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Compare each result with the oldest pending expectation.
	always @(posedge clk) begin
		kernel_out_t e;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h %h %h", $time,
					result_x, result_y, result_z);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("result_x", e.rx, result_x);
				check_field("result_y", e.ry, result_y);
				check_field("result_z", e.rz, result_z);
				check_field("beyond_radius", e.beyond, beyond_radius);
				check_field("saturated", e.sat, saturated);
				check_field("zero_distance", e.zdist, zero_distance);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("[sph_kernel_evaluator] ERROR");
			$finish;
		end
	end

	// Send one request, hold it until accepted, then idle if a gap is given.
	task automatic send_request(input op_t op, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input int gap);
		start <= 1'b1;
		driving = 1'b1;
		opcode <= op;
		offset_x <= x;
		offset_y <= y;
		offset_z <= z;
		do @(posedge clk); while (busy);
		pending_results.push_back(kernel_eval(op, x, y, z));
		if (gap > 0) begin
			start <= 1'b0;
			driving = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every pending result has come, then let the pipeline settle.
	task automatic drain;
		if (driving) begin
			start <= 1'b0;
			driving = 1'b0;
		end
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		kreg[idx] = (idx >= REG_POLY6) ? (value & MASK48) : (value & 64'hFFFF_FFFF);
		@(posedge clk);
	endtask

	task automatic load_regs(input logic [63:0] h, input logic [63:0] h2,
			input logic [63:0] ih2, input logic [63:0] i2h3, input logic [63:0] p6,
			input logic [63:0] sp, input logic [63:0] gr);
		drain();
		write_reg(REG_H, h);
		write_reg(REG_H2, h2);
		write_reg(REG_INV_H2, ih2);
		write_reg(REG_INV_2H3, i2h3);
		write_reg(REG_POLY6, p6);
		write_reg(REG_SPIKY, sp);
		write_reg(REG_GRAD, gr);
	endtask

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offset component: mostly inside the radius, sometimes anywhere.
	function automatic logic [31:0] pick_offset();
		logic [63:0] span;
		logic [31:0] m;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 3) return $urandom;
		if (sel == 3) return 32'h8000_0000;
		if (sel == 4) return 32'h7FFF_FFFF;
		if (sel == 5) return 32'd0;
		span = (kreg[REG_H] == 0) ? 64'd65536 : kreg[REG_H] >> 1;
		if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
		m = $urandom_range(0, span[31:0]);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	task automatic random_batch(input int count);
		logic [31:0] x, y, z;
		bit calm;
		for (int i = 0; i < count; i++) begin
			calm = (i % 100) > 70;
			x = pick_offset();
			y = pick_offset();
			z = pick_offset();
			if ($urandom_range(0, 24) == 0) begin
				x = 0;
				y = 0;
				z = 0;
			end
			send_request(op_t'($urandom_range(0, 3)), x, y, z, calm ? 0 : pick_gap());
		end
	endtask

	task automatic test_directed;
		for (int k = 0; k < 4; k++) begin
			send_request(op_t'(k), 0, 0, 0, 0);
			send_request(op_t'(k), 32'h4000, 32'hFFFF_C000, 32'h2000, 1);
			send_request(op_t'(k), 32'h10000, 0, 0, 0);
			send_request(op_t'(k), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2);
			send_request(op_t'(k), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
			send_request(op_t'(k), 0, 32'hFFFF_FFFF, 32'h1, 0);
		end
	endtask

	task automatic test_reset_values;
		random_batch(300);
	endtask

	task automatic test_radius_two;
		load_regs(64'h20000, 64'h40000, 64'h4000, 64'h1000, 64'd51336, 64'd1251645,
			-64'sd308022);
		test_directed();
		random_batch(300);
	endtask

	task automatic test_zero_regs;
		load_regs(0, 0, 0, 0, 0, 0, 0);
		random_batch(150);
	endtask

	task automatic test_max_regs;
		load_regs(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, MASK48,
			MASK48, 64'h8000_0000_0000);
		random_batch(250);
		load_regs(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, MASK48,
			MASK48, 64'h7FFF_FFFF_FFFF);
		random_batch(150);
	endtask

	task automatic test_random_regs;
		for (int k = 0; k < 4; k++) begin
			load_regs($urandom_range(0, 32'h0010_0000), $urandom, $urandom, $urandom,
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			random_batch(150);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		driving = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_POLY6;
		offset_x = 0;
		offset_y = 0;
		offset_z = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 0;
		pwdata = 0;
		kreg[REG_H] = RST_H;
		kreg[REG_H2] = RST_H2;
		kreg[REG_INV_H2] = RST_INV_H2;
		kreg[REG_INV_2H3] = RST_INV_2H3;
		kreg[REG_POLY6] = RST_POLY6;
		kreg[REG_SPIKY] = RST_SPIKY;
		kreg[REG_GRAD] = RST_GRAD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_reset_values();
		test_radius_two();
		test_zero_regs();
		test_max_regs();
		test_random_regs();
		drain();

		if (errors == 0) begin
			$display("[sph_kernel_evaluator] OK");
		end else begin
			$display("[sph_kernel_evaluator] ERROR");
		end
		$finish;
	end

endmodule
